[rtl/core/shuffled_combined_lcg_generator_defines.svh]
// Assertion macros shared by the shuffled combined LCG generator RTL.
// No dependencies; included by the files that carry assertions.
`ifndef SHUFFLED_COMBINED_LCG_GENERATOR_DEFINES_SVH
`define SHUFFLED_COMBINED_LCG_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define SCLG_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("sclg: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define SCLG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("sclg: next-cycle check failed");

`endif

[rtl/core/sclg_pkg.sv]
// Constants and types of the shuffled combined LCG generator.
// No dependencies; used by sclg_lcg_pair and the top level.
package sclg_pkg;

  localparam int unsigned VAL_W    = 31;
  localparam int unsigned MUL_W    = 16;
  localparam int unsigned PROD_W   = VAL_W + MUL_W;

  localparam logic [31:0] MOD_ONE      = 32'd2147483563;
  localparam logic [31:0] MOD_TWO      = 32'd2147483399;
  localparam logic [15:0] MUL_ONE      = 16'd40014;
  localparam logic [15:0] MUL_TWO      = 16'd40692;
  // 2^31 modulo each modulus, used to fold the high product bits
  localparam logic [7:0]  FOLD_ONE     = 8'd85;
  localparam logic [7:0]  FOLD_TWO     = 8'd249;
  localparam logic [30:0] WRAP_SPAN    = 31'd2147483562;
  localparam logic [30:0] SECOND_RESET = 31'd123456789;

  localparam int unsigned DEF_TABLE_SIZE = 32;

  // both generator values, moved as one group
  typedef struct packed {
    logic [VAL_W-1:0] g1;
    logic [VAL_W-1:0] g2;
  } gen_pair_t;

endpackage

[rtl/core/sclg_lcg_pair.sv]
// Two-stage modular step of both generators: multiply, then fold and reduce.
// Depends on sclg_pkg.
module sclg_lcg_pair (
  input  logic                clk_i,
  input  sclg_pkg::gen_pair_t x_i,
  output sclg_pkg::gen_pair_t y_o
);
  import sclg_pkg::*;

  logic [PROD_W-1:0] prod1_q, prod2_q;
  logic [31:0]       sum1, sum2;
  logic [31:0]       red1, red2;

  // stage 1: products, registered every cycle
  always_ff @(posedge clk_i) begin
    prod1_q <= PROD_W'(x_i.g1) * PROD_W'(MUL_ONE);
    prod2_q <= PROD_W'(x_i.g2) * PROD_W'(MUL_TWO);
  end

  // stage 2: hi*2^31 + lo == hi*fold + lo (mod m); the sum stays below 2m
  always_comb begin
    sum1 = 32'(prod1_q[VAL_W-1:0])
         + 32'(prod1_q[PROD_W-1:VAL_W]) * 32'(FOLD_ONE);
    sum2 = 32'(prod2_q[VAL_W-1:0])
         + 32'(prod2_q[PROD_W-1:VAL_W]) * 32'(FOLD_TWO);
    red1 = (sum1 >= MOD_ONE) ? sum1 - MOD_ONE : sum1;
    red2 = (sum2 >= MOD_TWO) ? sum2 - MOD_TWO : sum2;
    y_o.g1 = red1[VAL_W-1:0];
    y_o.g2 = red2[VAL_W-1:0];
  end

endmodule

[rtl/core/shuffled_combined_lcg_generator.sv]
// Top level of the shuffled combined LCG generator (two LCGs plus shuffle table).
// Depends on sclg_pkg, sclg_lcg_pair and shuffled_combined_lcg_generator_defines.svh.
//
//  channel  | dir | tdata bits             | tuser bits
//  s_axis   | in  | [30:0] seed_value      | [0] command (1 = reseed, then draw)
//  m_axis   | out | [30:0] random_value    | -
//
// A draw runs from accept through a product stage, reduce plus table write and index
// compute before the next accept; the table read-modify-write sets this pace.
// A reseed (or the first draw after reset) runs TABLE_SIZE+8 steps of the first
// generator, each a product state and a reduce state, before the draw itself.
// Reset is asynchronous, active low; the table needs no clearing pass.
// A new transaction is taken while the previous result waits on m_axis.
`include "shuffled_combined_lcg_generator_defines.svh"

module shuffled_combined_lcg_generator #(
  parameter int unsigned TABLE_SIZE = sclg_pkg::DEF_TABLE_SIZE
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [30:0] seed_value, [31] zero fill
  input  logic        s_axis_tuser,   // [0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [30:0] random_value, [31] zero fill
);
  import sclg_pkg::*;

  localparam int unsigned IW      = $clog2(TABLE_SIZE);
  localparam int unsigned CW      = $clog2(TABLE_SIZE + 8);
  localparam int unsigned DIVISOR = 1 + int'(WRAP_SPAN) / TABLE_SIZE;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_SEED_MUL = 3'd1;
  localparam logic [2:0] ST_SEED_RED = 3'd2;
  localparam logic [2:0] ST_SEED_IDX = 3'd3;
  localparam logic [2:0] ST_DRAW_MUL = 3'd4;
  localparam logic [2:0] ST_DRAW_RED = 3'd5;
  localparam logic [2:0] ST_DONE     = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [VAL_W-1:0] g1_q, g1_d;
  logic [VAL_W-1:0] g2_q, g2_d;
  logic [VAL_W-1:0] last_q, last_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [IW-1:0]    idx_q, idx_d;
  logic             out_valid_q, out_valid_d;
  logic [VAL_W-1:0] out_data_q, out_data_d;

  gen_pair_t        lcg_in, lcg_out;
  logic             in_fire, need_seed, out_load;
  logic [VAL_W-1:0] seed_sat;
  logic signed [32:0] diff, wrap_val;

  logic [VAL_W-1:0] mem [TABLE_SIZE];
  logic [VAL_W-1:0] rd_q;
  logic             mem_we;
  logic [IW-1:0]    mem_waddr;
  logic [VAL_W-1:0] mem_wdata;

  // generator step unit
  assign lcg_in.g1 = g1_q;
  assign lcg_in.g2 = g2_q;

  sclg_lcg_pair u_lcg_pair (
    .clk_i (clk_i),
    .x_i   (lcg_in),
    .y_o   (lcg_out)
  );

  // shuffle table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[idx_q];
  end

  // input handshake and seed conditioning
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign need_seed     = s_axis_tuser || (g1_q == '0);

  always_comb begin
    if (!s_axis_tuser || s_axis_tdata[VAL_W-1:0] == '0) begin
      seed_sat = VAL_W'(1);
    end else if (s_axis_tdata[VAL_W-1:0] > WRAP_SPAN) begin
      seed_sat = WRAP_SPAN;
    end else begin
      seed_sat = s_axis_tdata[VAL_W-1:0];
    end
  end

  // entry minus second generator, wrapped into 1..WRAP_SPAN
  always_comb begin
    diff = $signed({2'b00, rd_q}) - $signed({2'b00, lcg_out.g2});
    if (diff < 33'sd1) begin
      wrap_val = diff + $signed({2'b00, WRAP_SPAN});
    end else begin
      wrap_val = diff;
    end
  end

  // table index: last output divided by DIVISOR, saturated to the top entry
  always_comb begin
    idx_d = '0;
    for (int k = 1; k < int'(TABLE_SIZE); k++) begin
      if ({2'b00, last_q} >= 33'(k) * 33'(DIVISOR)) begin
        idx_d = IW'(k);
      end
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    g1_d        = g1_q;
    g2_d        = g2_q;
    last_d      = last_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    mem_we      = 1'b0;
    mem_waddr   = idx_q;
    mem_wdata   = lcg_out.g1;
    out_load    = 1'b0;

    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (need_seed) begin
            g1_d    = seed_sat;
            g2_d    = seed_sat;
            cnt_d   = CW'(TABLE_SIZE + 7);
            state_d = ST_SEED_MUL;
          end else begin
            state_d = ST_DRAW_MUL;
          end
        end
      end
      ST_SEED_MUL: begin
        state_d = ST_SEED_RED;
      end
      ST_SEED_RED: begin
        // warm-up step; the last TABLE_SIZE steps fill the table top down
        g1_d = lcg_out.g1;
        if (cnt_q < CW'(TABLE_SIZE)) begin
          mem_we    = 1'b1;
          mem_waddr = cnt_q[IW-1:0];
        end
        if (cnt_q == '0) begin
          last_d  = lcg_out.g1;
          state_d = ST_SEED_IDX;
        end else begin
          cnt_d   = cnt_q - CW'(1);
          state_d = ST_SEED_MUL;
        end
      end
      ST_SEED_IDX: begin
        state_d = ST_DRAW_MUL;
      end
      ST_DRAW_MUL: begin
        state_d = ST_DRAW_RED;
      end
      ST_DRAW_RED: begin
        g1_d    = lcg_out.g1;
        g2_d    = lcg_out.g2;
        mem_we  = 1'b1;
        last_d  = wrap_val[VAL_W-1:0];
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          out_data_d  = last_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      g1_q        <= '0;
      g2_q        <= SECOND_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      g1_q        <= g1_d;
      g2_q        <= g2_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    last_q     <= last_d;
    cnt_q      <= cnt_d;
    idx_q      <= idx_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_data_q};

  // checks
  `SCLG_ASSERT_IMPL(a_wrap_range, clk_i, rst_ni, state_q == ST_DRAW_RED, wrap_val >= 33'sd1 && wrap_val <= $signed({2'b00, WRAP_SPAN}))
  `SCLG_ASSERT_IMPL(a_gen_reduced, clk_i, rst_ni, state_q == ST_DRAW_RED, 32'(lcg_out.g1) < MOD_ONE && 32'(lcg_out.g2) < MOD_TWO)
  `SCLG_ASSERT_IMPL(a_seed_nonzero, clk_i, rst_ni, state_q == ST_SEED_RED, lcg_out.g1 != '0)
  `SCLG_ASSERT_NEXT(a_out_loaded, clk_i, rst_ni, out_load, m_axis_tvalid && m_axis_tdata[VAL_W-1:0] == $past(last_q))

endmodule

[tb/sv/shuffled_combined_lcg_generator_tb.sv]
// Self-checking testbench for the shuffled combined LCG generator.
// Depends on the shuffled_combined_lcg_generator RTL only; the expected
// draws come from an in-bench model of the two LCGs and the shuffle table.
module shuffled_combined_lcg_generator_tb;

  localparam int unsigned CLK_PERIOD     = 4;
  localparam int unsigned RESET_CYCLES   = 12;
  localparam int unsigned SLOTS          = 32;
  localparam int unsigned SLOT_W         = $clog2(SLOTS);
  localparam int unsigned RANDOM_ITEMS   = 1030;
  localparam int unsigned TAIL_CYCLES    = 120;
  localparam int unsigned TIMEOUT_CYCLES = 400_000;

  localparam logic [31:0] MODULUS_A   = 32'd2147483563;
  localparam logic [31:0] MODULUS_B   = 32'd2147483399;
  localparam logic [15:0] FACTOR_A    = 16'd40014;
  localparam logic [15:0] FACTOR_B    = 16'd40692;
  localparam logic [30:0] SPAN        = 31'd2147483562;
  localparam logic [30:0] B_START     = 31'd123456789;
  localparam logic [30:0] SLOT_DIV    = 31'(1 + SPAN / SLOTS);
  localparam logic [30:0] SEED_MAX31  = 31'h7FFF_FFFF;

  typedef enum logic {
    CMD_DRAW   = 1'b0,
    CMD_RESEED = 1'b1
  } lcg_cmd_e;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_SPARSE
  } ready_mode_e;

  typedef struct packed {
    lcg_cmd_e    cmd;
    logic [30:0] seed;
  } draw_req_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;   // [30:0] seed_value, [31] zero fill
  logic        s_axis_tuser  = 1'b0; // [0] command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;         // [30:0] random_value, [31] zero fill

  draw_req_t   pending_requests[$];
  logic [30:0] expected_draws[$];
  logic        in_fire  = 1'b0;
  int          mismatches = 0;

  // model state: both generators, last draw and the shuffle slots
  logic [30:0] gen_a = '0;
  logic [30:0] gen_b = B_START;
  logic [30:0] prev_draw = '0;
  logic [30:0] shuffle_slots[SLOTS];

  // sender burst bookkeeping
  int burst_left = 1;
  int gap_left   = 0;

  // receiver stall pattern
  ready_mode_e ready_mode  = READY_ALWAYS;
  int          ready_count = 0;

  shuffled_combined_lcg_generator DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // exact (mul * x) mod m
  function automatic logic [30:0] lcg_advance(logic [30:0] x, logic [15:0] mul,
                                              logic [31:0] m);
    longint unsigned prod;
    prod = longint'(x) * longint'(mul);
    return 31'(prod % longint'(m));
  endfunction

  // seed both generators and refill the shuffle slots with warm-up steps
  function automatic void reseed_slots(logic [30:0] seed);
    logic [30:0] s;
    s = (seed == '0) ? 31'd1 : seed;
    if (s > SPAN) s = SPAN;
    gen_a = s;
    gen_b = s;
    for (int n = SLOTS + 7; n >= 0; n--) begin
      gen_a = lcg_advance(gen_a, FACTOR_A, MODULUS_A);
      if (n < SLOTS) shuffle_slots[n] = gen_a;
    end
    prev_draw = shuffle_slots[0];
  endfunction

  // next shuffled draw for one accepted request
  function automatic logic [30:0] shuffled_draw(draw_req_t req);
    logic [30:0]       quot;
    logic [SLOT_W-1:0] idx;
    longint            diff;
    if (req.cmd == CMD_RESEED) reseed_slots(req.seed);
    else if (gen_a == '0) reseed_slots(31'd1);
    gen_a = lcg_advance(gen_a, FACTOR_A, MODULUS_A);
    gen_b = lcg_advance(gen_b, FACTOR_B, MODULUS_B);
    quot = prev_draw / SLOT_DIV;
    if (quot >= SLOTS) quot = 31'(SLOTS - 1);
    idx = quot[SLOT_W-1:0];
    diff = longint'(shuffle_slots[idx]) - longint'(gen_b);
    shuffle_slots[idx] = gen_a;
    if (diff < 1) diff += longint'(SPAN);
    prev_draw = 31'(diff);
    return prev_draw;
  endfunction

  task automatic add_request(lcg_cmd_e cmd, logic [30:0] seed);
    draw_req_t req;
    req.cmd  = cmd;
    req.seed = seed;
    pending_requests.push_back(req);
  endtask

  // seed picker: full-width, low end, top of range, near the 31-bit maximum (partly above range)
  function automatic logic [30:0] pick_seed();
    case ($urandom_range(3))
      0:       return 31'($urandom);
      1:       return 31'($urandom_range(0, 1000));
      2:       return SPAN - 31'($urandom_range(0, 1000));
      default: return SEED_MAX31 - 31'($urandom_range(0, 200));
    endcase
  endfunction

  // accept side: predict on input transactions, check output transactions
  always @(posedge clk_i) begin
    draw_req_t   req;
    logic [30:0] want;
    if (!rst_ni) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        req.cmd  = lcg_cmd_e'(s_axis_tuser);
        req.seed = s_axis_tdata[30:0];
        expected_draws.push_back(shuffled_draw(req));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_draws.size() == 0) begin
          $display("%0t: unexpected random_value, expected none, got %0d",
                   $time, m_axis_tdata[30:0]);
          mismatches++;
        end else begin
          want = expected_draws.pop_front();
          if (m_axis_tdata[30:0] !== want) begin
            $display("%0t: random_value mismatch, expected %0d, got %0d",
                     $time, want, m_axis_tdata[30:0]);
            mismatches++;
          end
        end
      end
    end
  end

  // driver: bursts of transactions separated by random gaps
  always @(negedge clk_i) begin
    logic      next_valid;
    draw_req_t req;
    if (rst_ni) begin
      next_valid = s_axis_tvalid;
      if (s_axis_tvalid && in_fire) begin
        next_valid = 1'b0;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(4) == 0) ? $urandom_range(32, 96)
                                                : $urandom_range(1, 12);
          gap_left   = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 14);
        end
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_requests.size() > 0) begin
          req = pending_requests.pop_front();
          s_axis_tdata <= {1'b0, req.seed};
          s_axis_tuser <= req.cmd;
          next_valid = 1'b1;
        end
      end
      s_axis_tvalid <= next_valid;
    end
  end

  // receiver: ready pattern switching between modes in random stretches
  always @(negedge clk_i) begin
    logic rdy;
    if (ready_count == 0) begin
      ready_mode  = ready_mode_e'($urandom_range(2));
      ready_count = $urandom_range(16, 96);
    end else begin
      ready_count--;
    end
    case (ready_mode)
      READY_ALWAYS: rdy = 1'b1;
      READY_COIN:   rdy = 1'($urandom_range(1));
      default:      rdy = ($urandom_range(7) == 0);
    endcase
    m_axis_tready <= rdy;
  end

  // stimulus, reset and end of run
  initial begin
    for (int n = 0; n < SLOTS; n++) shuffle_slots[n] = '0;

    // directed: draw before any seed, seed extremes, back-to-back draws
    add_request(CMD_DRAW, 31'h5555_5555);
    add_request(CMD_DRAW, SEED_MAX31);
    add_request(CMD_DRAW, 31'd0);
    add_request(CMD_RESEED, 31'd0);
    add_request(CMD_DRAW, 31'h2AAA_AAAA);
    add_request(CMD_RESEED, 31'd1);
    add_request(CMD_DRAW, 31'd0);
    add_request(CMD_RESEED, SPAN);
    add_request(CMD_DRAW, SEED_MAX31);
    add_request(CMD_RESEED, SPAN + 31'd1);
    add_request(CMD_RESEED, SEED_MAX31);
    add_request(CMD_DRAW, 31'd0);
    add_request(CMD_RESEED, 31'h5555_5555);
    add_request(CMD_RESEED, 31'h2AAA_AAAA);
    for (int n = 0; n < 8; n++) add_request(CMD_DRAW, 31'($urandom));
    add_request(CMD_RESEED, 31'd12345);
    add_request(CMD_DRAW, 31'd0);

    // random: mostly draws, with a reseed now and then
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(99) < 6) add_request(CMD_RESEED, pick_seed());
      else                        add_request(CMD_DRAW, 31'($urandom));
    end

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_requests.size() != 0 || s_axis_tvalid || expected_draws.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && expected_draws.size() == 0) begin
      $display("PASS shuffled_combined_lcg_generator");
    end else begin
      $display("FAIL shuffled_combined_lcg_generator");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("FAIL shuffled_combined_lcg_generator");
    $finish;
  end

endmodule
